FILE: rtl/core/sms_user_data_unpacker_unit_defines.svh
// assertion macros for the unpacker rtl
`ifndef SMS_USER_DATA_UNPACKER_UNIT_DEFINES_SVH
`define SMS_USER_DATA_UNPACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked property, masked while reset is high
`define SDU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sdu assertion failed");
// checked property, also checked during reset
`define SDU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sdu assertion failed");
`else
`define SDU_ASSERT(lbl, clk, rst, prop)
`define SDU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/sdu_pkg.sv
package sdu_pkg;

   localparam int unsigned PADDR_W = 3;
   localparam logic [0:0] REG_MODE_IDX = 1'b0;

   typedef enum logic [1:0] {
      MODE_GSM7  = 2'd0,
      MODE_OCTET = 2'd1,
      MODE_UCS2  = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   localparam logic [6:0]  ESC_SEPTET = 7'h1B;
   localparam logic [2:0]  LAST_PHASE = 3'd6;
   localparam logic [15:0] LINE_FEED  = 16'h000A;
   localparam logic [15:0] SPACE_CODE = 16'h0020;

   typedef struct packed {
      logic [15:0] code_point;
      logic        is_escape;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic       issue;
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } issue_type;

   function automatic logic [15:0] gsm_map(input logic [6:0] s);
      logic [15:0] cp;
      case (s)
         7'h00: cp = 16'h0040;  7'h01: cp = 16'h00a3;  7'h02: cp = 16'h0024;
         7'h03: cp = 16'h00a5;  7'h04: cp = 16'h00e8;  7'h05: cp = 16'h00e9;
         7'h06: cp = 16'h00f9;  7'h07: cp = 16'h00ec;  7'h08: cp = 16'h00f2;
         7'h09: cp = 16'h00c7;  7'h0a: cp = 16'h000a;  7'h0b: cp = 16'h00d8;
         7'h0c: cp = 16'h00f8;  7'h0d: cp = 16'h000d;  7'h0e: cp = 16'h00c5;
         7'h0f: cp = 16'h00e5;  7'h10: cp = 16'h0394;  7'h11: cp = 16'h005f;
         7'h12: cp = 16'h03a6;  7'h13: cp = 16'h0393;  7'h14: cp = 16'h039b;
         7'h15: cp = 16'h03a9;  7'h16: cp = 16'h03a0;  7'h17: cp = 16'h03a8;
         7'h18: cp = 16'h03a3;  7'h19: cp = 16'h0398;  7'h1a: cp = 16'h039e;
         7'h1b: cp = 16'h0000;  7'h1c: cp = 16'h00c6;  7'h1d: cp = 16'h00e6;
         7'h1e: cp = 16'h00df;  7'h1f: cp = 16'h00c9;  7'h20: cp = 16'h0020;
         7'h21: cp = 16'h0021;  7'h22: cp = 16'h0022;  7'h23: cp = 16'h0023;
         7'h24: cp = 16'h00a4;  7'h25: cp = 16'h0025;  7'h26: cp = 16'h0026;
         7'h27: cp = 16'h0027;  7'h28: cp = 16'h0028;  7'h29: cp = 16'h0029;
         7'h2a: cp = 16'h002a;  7'h2b: cp = 16'h002b;  7'h2c: cp = 16'h002c;
         7'h2d: cp = 16'h002d;  7'h2e: cp = 16'h002e;  7'h2f: cp = 16'h002f;
         7'h30: cp = 16'h0030;  7'h31: cp = 16'h0031;  7'h32: cp = 16'h0032;
         7'h33: cp = 16'h0033;  7'h34: cp = 16'h0034;  7'h35: cp = 16'h0035;
         7'h36: cp = 16'h0036;  7'h37: cp = 16'h0037;  7'h38: cp = 16'h0038;
         7'h39: cp = 16'h0039;  7'h3a: cp = 16'h003a;  7'h3b: cp = 16'h003b;
         7'h3c: cp = 16'h003c;  7'h3d: cp = 16'h003d;  7'h3e: cp = 16'h003e;
         7'h3f: cp = 16'h003f;  7'h40: cp = 16'h00a1;  7'h41: cp = 16'h0041;
         7'h42: cp = 16'h0042;  7'h43: cp = 16'h0043;  7'h44: cp = 16'h0044;
         7'h45: cp = 16'h0045;  7'h46: cp = 16'h0046;  7'h47: cp = 16'h0047;
         7'h48: cp = 16'h0048;  7'h49: cp = 16'h0049;  7'h4a: cp = 16'h004a;
         7'h4b: cp = 16'h004b;  7'h4c: cp = 16'h004c;  7'h4d: cp = 16'h004d;
         7'h4e: cp = 16'h004e;  7'h4f: cp = 16'h004f;  7'h50: cp = 16'h0050;
         7'h51: cp = 16'h0051;  7'h52: cp = 16'h0052;  7'h53: cp = 16'h0053;
         7'h54: cp = 16'h0054;  7'h55: cp = 16'h0055;  7'h56: cp = 16'h0056;
         7'h57: cp = 16'h0057;  7'h58: cp = 16'h0058;  7'h59: cp = 16'h0059;
         7'h5a: cp = 16'h005a;  7'h5b: cp = 16'h00c4;  7'h5c: cp = 16'h00d6;
         7'h5d: cp = 16'h00d1;  7'h5e: cp = 16'h00dc;  7'h5f: cp = 16'h00a7;
         7'h60: cp = 16'h00bf;  7'h61: cp = 16'h0061;  7'h62: cp = 16'h0062;
         7'h63: cp = 16'h0063;  7'h64: cp = 16'h0064;  7'h65: cp = 16'h0065;
         7'h66: cp = 16'h0066;  7'h67: cp = 16'h0067;  7'h68: cp = 16'h0068;
         7'h69: cp = 16'h0069;  7'h6a: cp = 16'h006a;  7'h6b: cp = 16'h006b;
         7'h6c: cp = 16'h006c;  7'h6d: cp = 16'h006d;  7'h6e: cp = 16'h006e;
         7'h6f: cp = 16'h006f;  7'h70: cp = 16'h0070;  7'h71: cp = 16'h0071;
         7'h72: cp = 16'h0072;  7'h73: cp = 16'h0073;  7'h74: cp = 16'h0074;
         7'h75: cp = 16'h0075;  7'h76: cp = 16'h0076;  7'h77: cp = 16'h0077;
         7'h78: cp = 16'h0078;  7'h79: cp = 16'h0079;  7'h7a: cp = 16'h007a;
         7'h7b: cp = 16'h00e4;  7'h7c: cp = 16'h00f6;  7'h7d: cp = 16'h00f1;
         7'h7e: cp = 16'h00fc;  7'h7f: cp = 16'h00e0;
         default: cp = 16'h0000;
      endcase
      return cp;
   endfunction

   function automatic result_type septet_result(input logic [6:0] s, input logic eighth,
                                                input logic last);
      result_type r;
      logic [15:0] cp;
      cp = gsm_map(s);
      r.last_of_run = last;
      if (s == ESC_SEPTET) begin
         r.code_point = 16'h0000;
         r.is_escape  = 1'b1;
      end else begin
         // line feed in the septet taken from the carry reads as padding
         r.code_point = (eighth && cp == LINE_FEED) ? SPACE_CODE : cp;
         r.is_escape  = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sdu_decode.sv
module sdu_decode import sdu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_message,
   input  mode_type    mode,
   input  logic        buf_free,
   output issue_type   issue
);

   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       first_ff;
   logic [2:0] phase_ff, phase_in;
   logic [6:0] carry_ff, carry_in;
   logic [7:0] high_ff, high_in;
   logic       half_ff, half_in;

   logic [2:0] ph, p;
   logic [6:0] cr;
   logic [7:0] hi;
   logic       hf;
   logic [7:0] shifted, cout8;
   logic [6:0] septet;
   logic       advance;

   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || buf_free;

   always_comb begin
      // new message flag clears all pending state before the byte is used
      ph = first_ff ? 3'd0 : phase_ff;
      cr = first_ff ? 7'd0 : carry_ff;
      hi = first_ff ? 8'd0 : high_ff;
      hf = first_ff ? 1'b0 : half_ff;
      p  = (ph > LAST_PHASE) ? 3'd0 : ph;
      shifted = (byte_ff & (8'h7F >> p)) << p;
      septet  = shifted[6:0] | cr;
      cout8   = byte_ff >> (3'd7 - p);
   end

   always_comb begin
      phase_in = ph;
      carry_in = cr;
      high_in  = hi;
      half_in  = hf;
      issue.issue  = advance;
      issue.valid0 = 1'b0;
      issue.valid1 = 1'b0;
      issue.res0   = septet_result(septet, 1'b0, 1'b1);
      issue.res1   = septet_result(cout8[6:0], 1'b1, 1'b1);
      case (mode)
         MODE_GSM7: begin
            issue.valid0 = 1'b1;
            if (p == LAST_PHASE) begin
               // seventh byte of the group also completes the eighth septet
               issue.valid1 = 1'b1;
               issue.res0   = septet_result(septet, 1'b0, 1'b0);
               phase_in     = 3'd0;
               carry_in     = 7'd0;
            end else begin
               phase_in = p + 3'd1;
               carry_in = cout8[6:0];
            end
         end
         MODE_OCTET: begin
            issue.valid0 = 1'b1;
            issue.res0   = '{code_point: {8'h00, byte_ff}, is_escape: 1'b0,
                             last_of_run: 1'b1};
         end
         MODE_UCS2: begin
            if (!hf) begin
               high_in = byte_ff;
               half_in = 1'b1;
            end else begin
               issue.valid0 = 1'b1;
               issue.res0   = '{code_point: {hi, byte_ff}, is_escape: 1'b0,
                                last_of_run: 1'b1};
               high_in = 8'd0;
               half_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 3'd0;
         carry_ff    <= 7'd0;
         high_ff     <= 8'd0;
         half_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            phase_ff <= phase_in;
            carry_ff <= carry_in;
            high_ff  <= high_in;
            half_ff  <= half_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff  <= req_data_byte;
         first_ff <= req_first_of_message;
      end
   end

endmodule

FILE: rtl/core/sdu_rsp_buf.sv
`include "sms_user_data_unpacker_unit_defines.svh"

module sdu_rsp_buf import sdu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  issue_type   issue,
   output logic        buf_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic        rsp_is_escape,
   output logic        rsp_last_of_run
);

   logic       a_valid_ff, a_valid_in;
   logic       b_valid_ff, b_valid_in;
   result_type a_ff, b_ff, sel;
   logic       pop;

   assign rsp_valid = a_valid_ff || b_valid_ff;
   assign pop       = rsp_valid && rsp_ready;
   // free when empty, or once the last held result leaves in this transfer
   assign buf_free  = (!a_valid_ff && !b_valid_ff) || (pop && !(a_valid_ff && b_valid_ff));

   assign sel             = a_valid_ff ? a_ff : b_ff;
   assign rsp_code_point  = sel.code_point;
   assign rsp_is_escape   = sel.is_escape;
   assign rsp_last_of_run = sel.last_of_run;

   always_comb begin
      a_valid_in = a_valid_ff && !pop;
      b_valid_in = b_valid_ff && !(pop && !a_valid_ff);
      if (issue.issue) begin
         a_valid_in = issue.valid0;
         b_valid_in = issue.valid1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.issue) begin
         a_ff <= issue.res0;
         b_ff <= issue.res1;
      end
   end

   `SDU_ASSERT(a_issue_when_free, clock, reset, issue.issue |-> buf_free)
   `SDU_ASSERT(a_second_is_last, clock, reset, b_valid_ff |-> b_ff.last_of_run)
   `SDU_ASSERT(a_first_has_partner, clock, reset,
      (a_valid_ff && !a_ff.last_of_run) |-> b_valid_ff)
   `SDU_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)

endmodule

FILE: rtl/core/sms_user_data_unpacker_unit.sv
// SMS user-data unpacker: one user-data byte per req transfer, decoded characters out on rsp.
// alphabet_mode selects GSM 7-bit septets through the default alphabet, plain bytes, or UCS2
// pairs taken high byte first; the reserved value gives no result. A byte sits in the input
// register and its results then wait in a two-entry result register, which frees the input
// register once it is empty or its last result leaves, so the seventh byte of a septet group,
// which gives two, holds the next byte until both have gone. The first UCS2 byte of a pair
// gives no result. last_of_run marks the final character caused by a byte. Write
// alphabet_mode at byte address 0 only while no transfer is in flight.
module sms_user_data_unpacker_unit import sdu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_of_message,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_code_point,
   output logic               rsp_is_escape,
   output logic               rsp_last_of_run,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   mode_type  mode_ff;
   issue_type issue;
   logic      buf_free;
   logic      reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[PADDR_W-1:2] == REG_MODE_IDX);
   assign prdata  = reg_hit ? {30'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GSM7;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         mode_ff <= mode_type'(pwdata[1:0]);
      end
   end

   sdu_decode u_decode (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_message (req_first_of_message),
      .mode                 (mode_ff),
      .buf_free             (buf_free),
      .issue                (issue)
   );

   sdu_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .issue           (issue),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_escape   (rsp_is_escape),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: dv/tb.sv
module tb import sdu_pkg::*; ();

   localparam int unsigned LIMIT_CYCLES    = 1_000_000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned HOLD_CYCLES     = 150;
   localparam int unsigned NUM_PHASES      = 16;
   localparam int unsigned ITEMS_PER_PHASE = 120;
   localparam int unsigned RSVD_ITEMS      = 20;
   localparam int unsigned NUM_DIR         = 22;
   localparam int unsigned MAX_PRINTS      = 20;
   localparam int unsigned RING_DEPTH      = 64;
   localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_MODE_IDX);

   // default alphabet, septet value to code point
   localparam logic [15:0] GSM_ALPHABET [128] = '{
      16'h0040, 16'h00a3, 16'h0024, 16'h00a5, 16'h00e8, 16'h00e9, 16'h00f9, 16'h00ec,
      16'h00f2, 16'h00c7, 16'h000a, 16'h00d8, 16'h00f8, 16'h000d, 16'h00c5, 16'h00e5,
      16'h0394, 16'h005f, 16'h03a6, 16'h0393, 16'h039b, 16'h03a9, 16'h03a0, 16'h03a8,
      16'h03a3, 16'h0398, 16'h039e, 16'h0000, 16'h00c6, 16'h00e6, 16'h00df, 16'h00c9,
      16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00a4, 16'h0025, 16'h0026, 16'h0027,
      16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
      16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
      16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
      16'h00a1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
      16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
      16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
      16'h0058, 16'h0059, 16'h005a, 16'h00c4, 16'h00d6, 16'h00d1, 16'h00dc, 16'h00a7,
      16'h00bf, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
      16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
      16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
      16'h0078, 16'h0079, 16'h007a, 16'h00e4, 16'h00f6, 16'h00f1, 16'h00fc, 16'h00e0
   };

   typedef struct {
      mode_type    mode;
      logic [7:0]  data_byte;
      logic        first;
      logic        typed;
      result_type  res;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_first_of_message = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_code_point;
   logic               rsp_is_escape;
   logic               rsp_last_of_run;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state
   mode_type    cur_mode = MODE_GSM7;
   logic [2:0]  grp_pos = '0;
   logic [6:0]  carry_sep = '0;
   logic [7:0]  ucs_hi = '0;
   logic        ucs_half = 1'b0;

   // expected characters in arrival order
   result_type  exp_ring [RING_DEPTH];
   int unsigned ring_wr = 0;
   int unsigned ring_rd = 0;
   int unsigned ring_count = 0;

   stim_row_type dir_rows [NUM_DIR];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned eighth_spaces = 0;
   int unsigned escapes = 0;
   int unsigned rsp_style = 0;
   bit          rsp_hold_req = 1'b0;

   sms_user_data_unpacker_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_message (req_first_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_code_point       (rsp_code_point),
      .rsp_is_escape        (rsp_is_escape),
      .rsp_last_of_run      (rsp_last_of_run),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d characters pending", cycles, ring_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
   endtask

   function automatic void ring_put(input result_type r);
      exp_ring[ring_wr] = r;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      ring_count++;
   endfunction

   function automatic result_type ring_take();
      result_type r;
      r = exp_ring[ring_rd];
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      ring_count--;
      return r;
   endfunction

   function automatic result_type septet_char(input logic [6:0] s, input logic eighth,
                                              input logic last);
      result_type r;
      r.last_of_run = last;
      if (s == ESC_SEPTET) begin
         r.code_point = 16'h0000;
         r.is_escape  = 1'b1;
      end else begin
         r.code_point = GSM_ALPHABET[s];
         r.is_escape  = 1'b0;
         // the septet rebuilt from the carry turns a line feed into a space
         if (eighth && r.code_point == LINE_FEED)
            r.code_point = SPACE_CODE;
      end
      return r;
   endfunction

   // advances the predictor by one byte, returns how many characters it gives
   function automatic int unsigned unpack_byte(input logic [7:0] b, input logic first,
                                               output result_type r0, output result_type r1);
      logic [2:0] p;
      logic [7:0] shifted;
      logic [6:0] sept;
      r0 = '0;
      r1 = '0;
      if (first) begin
         grp_pos   = '0;
         carry_sep = '0;
         ucs_half  = 1'b0;
         ucs_hi    = '0;
      end
      case (cur_mode)
         MODE_GSM7: begin
            p = (grp_pos > LAST_PHASE) ? 3'd0 : grp_pos;
            shifted = (b & (8'h7F >> p)) << p;
            sept = shifted[6:0] | carry_sep;
            carry_sep = 7'(b >> (3'd7 - p));
            if (p == LAST_PHASE) begin
               r0 = septet_char(sept, 1'b0, 1'b0);
               r1 = septet_char(carry_sep, 1'b1, 1'b1);
               carry_sep = '0;
               grp_pos = '0;
               return 2;
            end
            r0 = septet_char(sept, 1'b0, 1'b1);
            grp_pos = p + 3'd1;
            return 1;
         end
         MODE_OCTET: begin
            r0.code_point  = {8'h00, b};
            r0.last_of_run = 1'b1;
            return 1;
         end
         MODE_UCS2: begin
            if (!ucs_half) begin
               ucs_hi = b;
               ucs_half = 1'b1;
               return 0;
            end
            r0.code_point  = {ucs_hi, b};
            r0.last_of_run = 1'b1;
            ucs_half = 1'b0;
            ucs_hi = '0;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned gap_len(input int unsigned style);
      case (style)
         0: return 0;
         1: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 2);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
      endcase
   endfunction

   function automatic stim_row_type mk_row(input mode_type m, input logic [7:0] b,
                                           input logic first, input logic typed,
                                           input logic [15:0] cp, input logic esc,
                                           input logic last);
      stim_row_type r;
      r.mode = m;
      r.data_byte = b;
      r.first = first;
      r.typed = typed;
      r.res.code_point = cp;
      r.res.is_escape = esc;
      r.res.last_of_run = last;
      return r;
   endfunction

   // called at a clock edge where no input has been assigned yet
   task automatic send_byte(input logic [7:0] b, input logic first, input logic typed,
                            input result_type typed_res, input int unsigned gap);
      result_type r0, r1;
      int unsigned n;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_of_message <= first;
      do @(posedge clock); while (!req_ready);
      n = unpack_byte(b, first, r0, r1);
      bytes_sent++;
      if (typed) begin
         ring_put(typed_res);
      end else begin
         if (n > 0) ring_put(r0);
         if (n > 1) ring_put(r1);
      end
      if (n > 0 && r0.is_escape) escapes++;
      if (n > 1 && r1.is_escape) escapes++;
      if (n > 1 && r1.code_point == SPACE_CODE) eighth_spaces++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (ring_count != 0) @(posedge clock);
      // a byte that gives no character may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      data = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_mode(input mode_type m);
      logic [31:0] rd;
      apb_write(MODE_ADDR, 32'(m));
      cur_mode = m;
      apb_read(MODE_ADDR, rd);
      if (rd[1:0] !== m) report_mismatch("alphabet_mode readback", 32'(m), rd);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ring_count == 0) begin
            report_mismatch("character with none pending", 32'h0, 32'(rsp_code_point));
         end else begin
            want = ring_take();
            chars_checked++;
            if (rsp_code_point !== want.code_point)
               report_mismatch("code_point", 32'(want.code_point), 32'(rsp_code_point));
            if (rsp_is_escape !== want.is_escape)
               report_mismatch("is_escape", 32'(want.is_escape), 32'(rsp_is_escape));
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
         end
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = gap_len(rsp_style);
         end
      end
   end

   initial begin
      logic [31:0] rd;
      mode_type    m;
      int unsigned quota, sent, msg_len, send_style;
      logic        start_first, first;
      logic [7:0]  b;

      dir_rows[0]  = mk_row(MODE_GSM7,  8'h1B, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1);
      dir_rows[1]  = mk_row(MODE_GSM7,  8'hFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[2]  = mk_row(MODE_GSM7,  8'h00, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[3]  = mk_row(MODE_GSM7,  8'h80, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[4]  = mk_row(MODE_GSM7,  8'h55, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[5]  = mk_row(MODE_GSM7,  8'hAA, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      // seventh byte whose carry is a line feed
      dir_rows[6]  = mk_row(MODE_GSM7,  8'h14, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[7]  = mk_row(MODE_GSM7,  8'h00, 1'b1, 1'b1, 16'h0040, 1'b0, 1'b1);
      dir_rows[8]  = mk_row(MODE_GSM7,  8'h0A, 1'b1, 1'b1, 16'h000A, 1'b0, 1'b1);
      dir_rows[9]  = mk_row(MODE_GSM7,  8'h7F, 1'b1, 1'b1, 16'h00E0, 1'b0, 1'b1);
      dir_rows[10] = mk_row(MODE_GSM7,  8'h41, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[11] = mk_row(MODE_GSM7,  8'h42, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[12] = mk_row(MODE_OCTET, 8'h00, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1);
      dir_rows[13] = mk_row(MODE_OCTET, 8'hFF, 1'b0, 1'b1, 16'h00FF, 1'b0, 1'b1);
      dir_rows[14] = mk_row(MODE_UCS2,  8'hAB, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[15] = mk_row(MODE_UCS2,  8'hCD, 1'b0, 1'b1, 16'hABCD, 1'b0, 1'b1);
      // half pair dropped by the new message flag
      dir_rows[16] = mk_row(MODE_UCS2,  8'h12, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[17] = mk_row(MODE_UCS2,  8'hFF, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[18] = mk_row(MODE_UCS2,  8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1);
      dir_rows[19] = mk_row(MODE_RSVD,  8'h5A, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      dir_rows[20] = mk_row(MODE_RSVD,  8'hA5, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);
      // septet group starts anew, its phase cleared by the new message flags of the UCS2 rows
      dir_rows[21] = mk_row(MODE_GSM7,  8'h43, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      apb_read(MODE_ADDR, rd);
      if (rd[1:0] !== MODE_GSM7) report_mismatch("alphabet_mode after reset", 32'h0, rd);

      rsp_style = 2;
      for (int i = 0; i < NUM_DIR; i++) begin
         if (dir_rows[i].mode != cur_mode) begin
            drain_results();
            set_mode(dir_rows[i].mode);
         end
         send_byte(dir_rows[i].data_byte, dir_rows[i].first, dir_rows[i].typed,
                   dir_rows[i].res, $urandom_range(0, 2));
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0, 3: m = MODE_GSM7;
            1: m = MODE_UCS2;
            2: m = MODE_OCTET;
            5: m = MODE_RSVD;
            default: m = ($urandom_range(0, 1) != 0) ? MODE_GSM7
                                                     : mode_type'($urandom_range(1, 2));
         endcase
         drain_results();
         set_mode(m);
         send_style = ph % 3;
         rsp_style = $urandom_range(0, 2);
         // back-pressure: results held off while bytes keep coming
         if (ph == 3) rsp_hold_req = 1'b1;
         quota = (m == MODE_RSVD) ? RSVD_ITEMS : ITEMS_PER_PHASE;
         sent = 0;
         while (sent < quota) begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 20);
            start_first = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < msg_len && sent < quota; k++) begin
               first = (k == 0) ? start_first : ($urandom_range(0, 39) == 0);
               b = 8'($urandom_range(0, 255));
               if (m == MODE_GSM7 && !first && grp_pos == LAST_PHASE &&
                   $urandom_range(0, 3) == 0)
                  b = {(($urandom_range(0, 1) != 0) ? ESC_SEPTET : LINE_FEED[6:0]),
                       1'($urandom_range(0, 1))};
               send_byte(b, first, 1'b0, '0,
                         (ph == 3 && sent < 40) ? 0 : gap_len(send_style));
               sent++;
               if (ph == 7 && sent == quota / 2) drain_results();
            end
         end
      end

      drain_results();
      $display("sent %0d bytes over 7-bit, 8-bit, UCS2 and unused modes; %0d chars checked",
               bytes_sent, chars_checked);
      $display("escape chars %0d, eighth-septet spaces %0d, mismatches %0d",
               escapes, eighth_spaces, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sdu_pkg.sv
rtl/core/sdu_decode.sv
rtl/core/sdu_rsp_buf.sv
rtl/core/sms_user_data_unpacker_unit.sv
dv/tb.sv
